/* src/rmap_pkg.sv */
package rmap_pkg;

    localparam int MAX_MASKS   = 8;
    localparam int MAX_ROWS    = 256;
    localparam int MAX_COLUMNS = 256;
    localparam int CHANNELS    = 8;

    localparam int MASK_W  = 3;
    localparam int ROW_W   = 8;
    localparam int CH_W    = 3;
    localparam int SPAN_W  = 9;
    localparam int SUM_W   = 33;
    localparam int CNT_W   = 17;
    localparam int SADDR_W = MASK_W + ROW_W;
    localparam int SUMS_W  = MASK_W + CH_W;
    localparam int QW      = 33;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_PIXEL = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_ROWS     = 2'd0,
        REG_COLUMNS  = 2'd1,
        REG_CHANNELS = 2'd2,
        REG_MASKS    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [2:0]         mask_index;
        logic [7:0]         row;
        logic signed [15:0] span_start;
        logic signed [15:0] span_end;
        logic [7:0]         column;
        logic [2:0]         channel;
        logic signed [15:0] pixel_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         out_mask;
        logic [2:0]         out_channel;
        logic signed [15:0] average;
        logic [16:0]        pixel_count;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic             start;
        logic [QW-1:0]    dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic          done;
        logic [QW-1:0] quotient;
    } div_rsp_t;

endpackage

/* src/rmap_divider.sv */
module rmap_divider
    import rmap_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [QW-1:0]    q_reg, q_next;
    logic [CNT_W:0]   r_reg, r_next;
    logic [CNT_W-1:0] d_reg;
    logic [5:0]       n_reg, n_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W+1:0] trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        n_next    = n_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (req.start)
        begin
            q_next    = req.dividend;
            r_next    = '0;
            n_next    = 6'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {r_reg, q_reg[QW-1]} - {2'b00, d_reg};
            if (!trial[CNT_W+1])
            begin
                r_next = trial[CNT_W:0];
                q_next = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[CNT_W-1:0], q_reg[QW-1]};
                q_next = {q_reg[QW-2:0], 1'b0};
            end
            n_next = n_reg - 6'd1;
            if (n_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            n_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            n_reg    <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (req.start)
        begin
            d_reg <= req.divisor;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

/* src/rle_masked_average_pool_unit.sv */
// Channel     Signals                         Direction  Handshake
// command     start, busy, in_item            in         start && !busy
// result      out_valid, out_item             out        out_valid, one cycle
// config      cfg_valid, cfg_ready, cfg_*     in         cfg_valid && cfg_ready
//
// After reset a clearing pass empties the span memory, sums and pixel counts; busy is high.
// A clear command runs the same clearing pass.
// Loads and out-of-range pixels keep busy low; a pixel reads, checks and adds per mask in use.
// A read fetches the sum, runs the bit-serial divider and gives a result for each channel.
// Results cannot be stalled; each transfer is one strobed cycle.
module rle_masked_average_pool_unit
    import rmap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_item_t    in_item,
    output logic        out_valid,
    output out_item_t   out_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CLR   = 9'b000000010,
        S_PXRD  = 9'b000000100,
        S_PXCHK = 9'b000001000,
        S_PXACC = 9'b000010000,
        S_RDSUM = 9'b000100000,
        S_RDDIV = 9'b001000000,
        S_RDWT  = 9'b010000000,
        S_RDOUT = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [8:0] rows_reg, cols_reg;
    logic [3:0] chans_reg, masks_reg;
    logic [8:0] rows_c, cols_c;
    logic [3:0] chans_c, masks_c;

    logic [SPAN_W-1:0] st_mem [0:MAX_MASKS*MAX_ROWS-1];
    logic [SPAN_W-1:0] en_mem [0:MAX_MASKS*MAX_ROWS-1];
    logic [SPAN_W-1:0] st_rd_reg, en_rd_reg;

    logic signed [SUM_W-1:0] sum_mem [0:MAX_MASKS*CHANNELS-1];
    logic signed [SUM_W-1:0] sum_rd_reg;
    logic [CNT_W-1:0] cnt_reg [0:MAX_MASKS-1];

    logic [SADDR_W:0] clr_reg;
    logic [MASK_W:0]  m_reg;
    logic [CH_W:0]    c_reg;
    logic             neg_reg;
    in_item_t         it_reg;
    logic             hit_reg;

    div_req_t dreq;
    div_rsp_t drsp;
    out_item_t out_reg;
    logic      out_v_reg;

    logic [SADDR_W-1:0] rd_addr;
    logic               sp_we;
    logic [SADDR_W-1:0] sp_waddr;
    logic [SPAN_W-1:0]  sp_wst, sp_wen;
    logic signed [16:0] lo_v, hi_v;
    logic [MASK_W-1:0]  m_idx;
    logic [SUMS_W-1:0]  sum_addr;
    logic signed [SUM_W:0] acc;
    logic signed [SUM_W-1:0] acc_sat;
    logic [CNT_W-1:0]   ncount;
    logic [QW-1:0]      quo;
    logic signed [16:0] avg;
    logic               accept;

    assign rows_c  = (rows_reg == 9'd0) ? 9'd1 : rows_reg;
    assign cols_c  = (cols_reg == 9'd0) ? 9'd1 : cols_reg;
    assign chans_c = (chans_reg == 4'd0) ? 4'd1 : (chans_reg > 4'd8 ? 4'd8 : chans_reg);
    assign masks_c = (masks_reg == 4'd0) ? 4'd1 : (masks_reg > 4'd8 ? 4'd8 : masks_reg);

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= 9'd256;
            cols_reg  <= 9'd256;
            chans_reg <= 4'd8;
            masks_reg <= 4'd8;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_ROWS:     rows_reg  <= cfg_data[8:0];
                REG_COLUMNS:  cols_reg  <= cfg_data[8:0];
                REG_CHANNELS: chans_reg <= cfg_data[3:0];
                REG_MASKS:    masks_reg <= cfg_data[3:0];
                default:      ;
            endcase
        end
    end

    assign m_idx    = m_reg[MASK_W-1:0];
    assign rd_addr  = {m_idx, it_reg.row};
    assign sum_addr = (state_reg == S_IDLE || state_reg == S_RDSUM)
                      ? {it_reg.mask_index, c_reg[CH_W-1:0]}
                      : {m_idx, it_reg.channel};
    assign ncount   = cnt_reg[it_reg.mask_index];

    always_comb
    begin
        lo_v   = in_item.span_start < 0 ? 17'sd0 : 17'(in_item.span_start);
        hi_v   = (17'(in_item.span_end) > $signed({8'd0, cols_c}))
                 ? $signed({8'd0, cols_c}) : 17'(in_item.span_end);
        sp_we    = 1'b0;
        sp_waddr = {in_item.mask_index, in_item.row};
        sp_wst   = '0;
        sp_wen   = '0;
        if (state_reg == S_CLR)
        begin
            sp_we    = 1'b1;
            sp_waddr = clr_reg[SADDR_W-1:0];
        end
        else if (accept && in_item.cmd == CMD_LOAD)
        begin
            sp_we = 1'b1;
            if (hi_v > lo_v)
            begin
                sp_wst = lo_v[SPAN_W-1:0];
                sp_wen = hi_v[SPAN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sp_we)
        begin
            st_mem[sp_waddr] <= sp_wst;
            en_mem[sp_waddr] <= sp_wen;
        end
        st_rd_reg <= st_mem[rd_addr];
        en_rd_reg <= en_mem[rd_addr];
    end

    always_comb
    begin
        acc     = 34'(sum_rd_reg) + 34'(it_reg.pixel_value);
        acc_sat = acc[SUM_W-1:0];
        if (acc[SUM_W] != acc[SUM_W-1])
        begin
            acc_sat = acc[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLR && clr_reg < (SADDR_W+1)'(MAX_MASKS*CHANNELS))
        begin
            sum_mem[clr_reg[SUMS_W-1:0]] <= '0;
        end
        else if (state_reg == S_PXACC && hit_reg)
        begin
            sum_mem[sum_addr] <= acc_sat;
        end
        sum_rd_reg <= sum_mem[sum_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_MASKS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (state_reg == S_CLR && clr_reg == '0)
        begin
            for (int i = 0; i < MAX_MASKS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (state_reg == S_PXACC && hit_reg && it_reg.channel == '0
                 && cnt_reg[m_idx] != COUNT_MAX)
        begin
            cnt_reg[m_idx] <= cnt_reg[m_idx] + 1'b1;
        end
    end

    always_comb
    begin
        dreq.start    = (state_reg == S_RDDIV);
        dreq.dividend = sum_rd_reg[SUM_W-1] ? QW'(-sum_rd_reg) : QW'(sum_rd_reg);
        dreq.divisor  = ncount;
    end

    rmap_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_comb
    begin
        quo = drsp.quotient;
        if (ncount == '0)
        begin
            avg = 17'sd0;
        end
        else if (!neg_reg)
        begin
            avg = (quo > QW'(32767)) ? 17'sd32767 : $signed({1'b0, quo[15:0]});
        end
        else
        begin
            avg = (quo > QW'(32768)) ? -17'sd32768 : -$signed({1'b0, quo[15:0]});
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_t'(in_item.cmd))
                        CMD_PIXEL:
                            if ({1'b0, in_item.row} < rows_c && {1'b0, in_item.column} < cols_c
                                && {1'b0, in_item.channel} < chans_c)
                                state_next = S_PXRD;
                        CMD_READ:  state_next = S_RDSUM;
                        CMD_CLEAR: state_next = S_CLR;
                        default:   ;
                    endcase
                end
            end
            S_CLR:   if (clr_reg == (SADDR_W+1)'(MAX_MASKS*MAX_ROWS-1)) state_next = S_IDLE;
            S_PXRD:  state_next = S_PXCHK;
            S_PXCHK: state_next = S_PXACC;
            S_PXACC: state_next = ({1'b0, m_reg} + 5'd1 >= {1'b0, masks_c}) ? S_IDLE : S_PXRD;
            S_RDSUM: state_next = S_RDDIV;
            S_RDDIV: state_next = S_RDWT;
            S_RDWT:  if (drsp.done) state_next = S_RDOUT;
            S_RDOUT: state_next = (c_reg + 4'd1 >= chans_c) ? S_IDLE : S_RDSUM;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            m_reg     <= '0;
            c_reg     <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_v_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    clr_reg <= '0;
                    m_reg   <= '0;
                    c_reg   <= '0;
                end
                S_CLR:   clr_reg <= clr_reg + 1'b1;
                S_PXACC: m_reg   <= m_reg + 1'b1;
                S_RDOUT:
                begin
                    c_reg     <= c_reg + 1'b1;
                    out_v_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            it_reg <= in_item;
        end
        if (state_reg == S_PXCHK)
        begin
            hit_reg <= ({1'b0, it_reg.column} >= st_rd_reg) && ({1'b0, it_reg.column} < en_rd_reg);
        end
        if (state_reg == S_RDDIV)
        begin
            neg_reg <= sum_rd_reg[SUM_W-1];
        end
        if (state_reg == S_RDOUT)
        begin
            out_reg.out_mask    <= it_reg.mask_index;
            out_reg.out_channel <= c_reg[CH_W-1:0];
            out_reg.average     <= avg[15:0];
            out_reg.pixel_count <= ncount;
            out_reg.last        <= (c_reg + 4'd1 >= chans_c);
        end
    end

    assign out_valid = out_v_reg;
    assign out_item  = out_reg;

endmodule

/* src/rmap_checker.sv */
module rmap_checker
    import rmap_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      out_valid,
    input out_item_t out_item
);

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |=> !out_valid)
        else $error("result strobe held for more than one cycle");

    a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(busy))
        else $error("result while idle");

    a_first_ch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.out_channel == 3'd0 |-> $past(busy, 2))
        else $error("read began without command");

    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.pixel_count == '0 |-> out_item.average == '0)
        else $error("nonzero average with empty mask");

endmodule

bind rle_masked_average_pool_unit rmap_checker u_rmap_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item)
);

/* bench/rle_masked_average_pool_unit_test.sv */
module rle_masked_average_pool_unit_test;
    import rmap_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_item_t    in_item;
    logic        out_valid;
    out_item_t   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    logic [8:0]  span_lo [MAX_MASKS*MAX_ROWS];
    logic [8:0]  span_hi [MAX_MASKS*MAX_ROWS];
    longint      ch_sum [MAX_MASKS*CHANNELS];
    int unsigned px_count [MAX_MASKS];
    int unsigned rows_cfg;
    int unsigned cols_cfg;
    int unsigned chans_cfg;
    int unsigned masks_cfg;

    out_item_t   pending_averages[$];
    int          mismatches;
    longint      cycle_count;

    // Rows of the directed part: item, whether averages are typed in, and
    // the typed average and pixel count for every channel of the row when they are.
    typedef struct {
        in_item_t     item;
        bit           typed;
        logic [15:0]  typed_avg;
        logic [16:0]  typed_count;
    } stim_row_t;

    stim_row_t   plan[$];

    rle_masked_average_pool_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 3000000)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic int unsigned clamp_range(int unsigned v, int unsigned lo,
                                                int unsigned hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic void wipe_pool_state();
        foreach (span_lo[i])
        begin
            span_lo[i] = '0;
            span_hi[i] = '0;
        end
        foreach (ch_sum[i])
        begin
            ch_sum[i] = 0;
        end
        foreach (px_count[i])
        begin
            px_count[i] = 0;
        end
    endfunction

    function automatic void pool_apply_reg(reg_idx_t idx, logic [31:0] data);
        case (idx)
            REG_ROWS:     rows_cfg  = data[8:0];
            REG_COLUMNS:  cols_cfg  = data[8:0];
            REG_CHANNELS: chans_cfg = data[3:0];
            REG_MASKS:    masks_cfg = data[3:0];
            default: ;
        endcase
    endfunction

    function automatic void predict_pool(in_item_t it);
        int unsigned rows;
        int unsigned cols;
        int unsigned chans;
        int unsigned masks;
        int          lo;
        int          hi;
        int unsigned at;
        longint      s;
        longint      avg;
        int unsigned n;
        out_item_t   r;
        rows  = clamp_range(rows_cfg, 1, MAX_ROWS);
        cols  = clamp_range(cols_cfg, 1, MAX_COLUMNS);
        chans = clamp_range(chans_cfg, 1, CHANNELS);
        masks = clamp_range(masks_cfg, 1, MAX_MASKS);
        case (cmd_t'(it.cmd))
            CMD_LOAD:
            begin
                lo = it.span_start < 0 ? 0 : int'(it.span_start);
                hi = int'(it.span_end) > int'(cols) ? int'(cols) : int'(it.span_end);
                at = it.mask_index * MAX_ROWS + it.row;
                if (hi > lo)
                begin
                    span_lo[at] = 9'(lo);
                    span_hi[at] = 9'(hi);
                end
                else
                begin
                    span_lo[at] = '0;
                    span_hi[at] = '0;
                end
            end
            CMD_PIXEL:
            begin
                if (it.row < rows && it.column < cols && it.channel < chans)
                begin
                    for (int m = 0; m < masks; m++)
                    begin
                        at = m * MAX_ROWS + it.row;
                        if (it.column >= span_lo[at] && it.column < span_hi[at])
                        begin
                            s = ch_sum[m*CHANNELS+it.channel] + longint'(it.pixel_value);
                            if (s > 64'sd4294967295)
                            begin
                                s = 64'sd4294967295;
                            end
                            if (s < -64'sd4294967296)
                            begin
                                s = -64'sd4294967296;
                            end
                            ch_sum[m*CHANNELS+it.channel] = s;
                            if (it.channel == 0 && px_count[m] < COUNT_MAX)
                            begin
                                px_count[m]++;
                            end
                        end
                    end
                end
            end
            CMD_READ:
            begin
                n = px_count[it.mask_index];
                for (int c = 0; c < chans; c++)
                begin
                    avg = 0;
                    if (n != 0)
                    begin
                        avg = ch_sum[it.mask_index*CHANNELS+c] / longint'(n);
                        if (avg > 32767)
                        begin
                            avg = 32767;
                        end
                        if (avg < -32768)
                        begin
                            avg = -32768;
                        end
                    end
                    r.out_mask    = it.mask_index;
                    r.out_channel = 3'(c);
                    r.average     = avg[15:0];
                    r.pixel_count = n[16:0];
                    r.last        = (c + 1 == chans);
                    pending_averages.push_back(r);
                end
            end
            default: wipe_pool_state();
        endcase
    endfunction

    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n && out_valid)
        begin
            if (pending_averages.size() == 0)
            begin
                $error("unexpected result mask %0d channel %0d",
                       out_item.out_mask, out_item.out_channel);
                mismatches++;
            end
            else
            begin
                exp_r = pending_averages.pop_front();
                if (out_item.out_mask !== exp_r.out_mask)
                begin
                    $error("out_mask expected %0d actual %0d", exp_r.out_mask,
                           out_item.out_mask);
                    mismatches++;
                end
                if (out_item.out_channel !== exp_r.out_channel)
                begin
                    $error("out_channel expected %0d actual %0d", exp_r.out_channel,
                           out_item.out_channel);
                    mismatches++;
                end
                if (out_item.average !== exp_r.average)
                begin
                    $error("average expected %0d actual %0d", exp_r.average,
                           out_item.average);
                    mismatches++;
                end
                if (out_item.pixel_count !== exp_r.pixel_count)
                begin
                    $error("pixel_count expected %0d actual %0d", exp_r.pixel_count,
                           out_item.pixel_count);
                    mismatches++;
                end
                if (out_item.last !== exp_r.last)
                begin
                    $error("last expected %0d actual %0d", exp_r.last, out_item.last);
                    mismatches++;
                end
            end
        end
    end

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
        begin
            n = 0;
        end
        repeat (n + 1) @(negedge clk);
    endtask

    task automatic issue_command(in_item_t it);
        in_item <= it;
        start   <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        predict_pool(it);
        @(negedge clk);
        start   <= 1'b0;
        in_item <= in_item_t'($urandom());
    endtask

    task automatic wait_drained();
        while (pending_averages.size() != 0)
        begin
            @(negedge clk);
        end
        // Loads and pixels make no results and may still be in progress.
        repeat (80) @(negedge clk);
        while (busy)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        pool_apply_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic in_item_t make_item(cmd_t c, int m, int row, int s0, int s1,
                                           int col, int ch, int v);
        in_item_t it;
        it.cmd         = c;
        it.mask_index  = 3'(m);
        it.row         = 8'(row);
        it.span_start  = 16'(s0);
        it.span_end    = 16'(s1);
        it.column      = 8'(col);
        it.channel     = 3'(ch);
        it.pixel_value = 16'(v);
        return it;
    endfunction

    function automatic void add_row(in_item_t it, bit typed, logic [15:0] avg,
                                    logic [16:0] cnt);
        stim_row_t r;
        r.item        = it;
        r.typed       = typed;
        r.typed_avg   = avg;
        r.typed_count = cnt;
        plan.push_back(r);
    endfunction

    function automatic in_item_t random_item(int unsigned mask_lim, int unsigned row_lim);
        in_item_t it;
        int       k;
        it = in_item_t'({$urandom(), $urandom(), $urandom()});
        it.mask_index = 3'($urandom_range(0, mask_lim - 1));
        it.row        = 8'($urandom_range(0, row_lim - 1));
        k = $urandom_range(0, 99);
        if (k < 30)
        begin
            it.cmd = CMD_LOAD;
            if ($urandom_range(0, 4) != 0)
            begin
                it.span_start = 16'($signed($urandom_range(0, 40)) - 8);
                it.span_end   = 16'(it.span_start + $signed($urandom_range(0, 300)) - 20);
            end
        end
        else if (k < 85)
        begin
            it.cmd = CMD_PIXEL;
            if ($urandom_range(0, 4) != 0)
            begin
                it.column = 8'($urandom_range(0, 40));
            end
        end
        else if (k < 99)
        begin
            it.cmd = CMD_READ;
        end
        else
        begin
            it.cmd = CMD_CLEAR;
        end
        return it;
    endfunction

    initial
    begin
        in_item_t    it;
        stim_row_t   r;
        int          n_exp;
        int unsigned rl;
        mismatches   = 0;
        start        = 1'b0;
        in_item      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_ROWS;
        cfg_data     = '0;
        rows_cfg     = 256;
        cols_cfg     = 256;
        chans_cfg    = 8;
        masks_cfg    = 8;
        wipe_pool_state();
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Read after reset gives zero on every channel.
        add_row(make_item(CMD_READ, 7, 0, 0, 0, 0, 0, 0), 1'b1, 16'd0, 17'd0);
        add_row(make_item(CMD_LOAD, 0, 0, -32768, 32767, 0, 0, 0), 1'b0, 0, 0);
        add_row(make_item(CMD_LOAD, 1, 0, 5, 5, 0, 0, 0), 1'b0, 0, 0);
        add_row(make_item(CMD_LOAD, 2, 255, 255, 256, 0, 0, 0), 1'b0, 0, 0);
        add_row(make_item(CMD_LOAD, 3, 0, 10, -32768, 0, 0, 0), 1'b0, 0, 0);
        add_row(make_item(CMD_PIXEL, 0, 0, 0, 0, 0, 0, 32767), 1'b0, 0, 0);
        add_row(make_item(CMD_PIXEL, 0, 0, 0, 0, 0, 0, 32767), 1'b0, 0, 0);
        add_row(make_item(CMD_PIXEL, 0, 0, 0, 0, 255, 7, -32768), 1'b0, 0, 0);
        add_row(make_item(CMD_PIXEL, 0, 0, 0, 0, 5, 3, -1), 1'b0, 0, 0);
        add_row(make_item(CMD_PIXEL, 0, 255, 0, 0, 255, 0, -32768), 1'b0, 0, 0);
        add_row(make_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0), 1'b0, 0, 0);
        add_row(make_item(CMD_READ, 1, 0, 0, 0, 0, 0, 0), 1'b1, 16'd0, 17'd0);
        add_row(make_item(CMD_READ, 2, 0, 0, 0, 0, 0, 0), 1'b0, 0, 0);
        add_row(make_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1'b0, 0, 0);
        add_row(make_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0), 1'b1, 16'd0, 17'd0);

        foreach (plan[i])
        begin
            r = plan[i];
            n_exp = pending_averages.size();
            issue_command(r.item);
            if (r.typed)
            begin
                for (int j = n_exp; j < pending_averages.size(); j++)
                begin
                    if (pending_averages[j].average !== r.typed_avg
                        || pending_averages[j].pixel_count !== r.typed_count)
                    begin
                        $error("average expected %0d actual %0d in row %0d",
                               r.typed_avg, pending_averages[j].average, i);
                        mismatches++;
                    end
                end
            end
            idle_gap();
        end
        wait_drained();

        // Random phases, each with its own register settings.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_ROWS, 1);
                    write_reg(REG_COLUMNS, 1);
                    write_reg(REG_CHANNELS, 1);
                    write_reg(REG_MASKS, 1);
                end
                1:
                begin
                    write_reg(REG_ROWS, 4);
                    write_reg(REG_COLUMNS, 32);
                    write_reg(REG_CHANNELS, 3);
                    write_reg(REG_MASKS, 4);
                end
                2:
                begin
                    write_reg(REG_ROWS, 0);
                    write_reg(REG_COLUMNS, 511);
                    write_reg(REG_CHANNELS, 15);
                    write_reg(REG_MASKS, 0);
                end
                3:
                begin
                    write_reg(REG_ROWS, 256);
                    write_reg(REG_COLUMNS, 256);
                    write_reg(REG_CHANNELS, 8);
                    write_reg(REG_MASKS, 8);
                end
                default:
                begin
                    write_reg(REG_ROWS, $urandom());
                    write_reg(REG_COLUMNS, $urandom());
                    write_reg(REG_CHANNELS, $urandom());
                    write_reg(REG_MASKS, $urandom());
                end
            endcase
            rl = (ph == 3) ? 256 : 4;
            for (int k = 0; k < 17; k++)
            begin
                it = random_item(8, rl);
                if (ph == 3 && $urandom_range(0, 3) != 0)
                begin
                    it.row = 8'($urandom_range(0, 3));
                end
                issue_command(it);
                idle_gap();
            end
            wait_drained();
        end

        if (mismatches == 0 && pending_averages.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
